// ===== hdl/u8d_pkg.sv =====
package u8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int BITS_W  = 7;
    localparam int CNT_W   = 2;

    // queue between front and back, power-of-two depth
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h00080;
    localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h00800;
    localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h10000;
    localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURROGATE_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] SURROGATE_HI   = 21'h0DFFF;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        byte_class_t         cls;
        logic [BITS_W-1:0]   bits;
        logic                last;
    } u8d_item_t;

endpackage

// ===== hdl/u8d_in_if.sv =====
interface u8d_in_if;
    logic                          valid;
    logic                          ready;
    logic [u8d_pkg::BYTE_W-1:0]    text_byte;
    logic                          message_end;

    modport source (output valid, output text_byte, output message_end, input ready);
    modport sink   (input valid, input text_byte, input message_end, output ready);
endinterface

// ===== hdl/u8d_out_if.sv =====
interface u8d_out_if;
    logic                        valid;
    logic                        ready;
    logic [u8d_pkg::CP_W-1:0]    code_point;
    logic                        invalid;
    logic                        run_last;

    modport source (output valid, output code_point, output invalid, output run_last,
                    input ready);
    modport sink   (input valid, input code_point, input invalid, input run_last,
                    output ready);
endinterface

// ===== hdl/utf8_validating_decoder_core.sv =====
// Strict UTF-8 decoder.
// text: one request per raw byte, message_end marks the final byte of a message.
// decoded: one request per finished code point, or a single invalid request
//   (code_point zero, run_last set) on the first error of a message; the rest
//   of that message is then dropped. run_last is set on the final result of a
//   message.
// Throughput: one byte per cycle sustained. Lead bytes and continuation bytes
//   that do not close a sequence produce no result.
// Path: a closing byte is written into the queue when it is accepted and is
//   decoded into the result register on the edge that pops it; that register
//   drives decoded.
// The front classifies each byte and writes it to a two-entry queue; the back
//   end pops one entry per cycle while its result register is free or being
//   taken.
// Reset clears the decoder state, empties the queue and drops any pending result.
// When decoded stalls, the result register holds, the queue fills behind it,
//   and text.ready falls once the queue is full.
module utf8_validating_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    u8d_in_if.sink      text,
    u8d_out_if.source   decoded
);
    import u8d_pkg::*;

    logic        q_full;
    logic        push;
    u8d_item_t   push_item;
    logic        pop;
    logic        q_valid;
    u8d_item_t   q_item;

    u8d_front u_front (
        .text      (text),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    u8d_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    u8d_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .decoded (decoded)
    );

endmodule

// ===== hdl/u8d_front.sv =====
module u8d_front (
    u8d_in_if.sink              text,
    input  logic                q_full,
    output logic                push,
    output u8d_pkg::u8d_item_t  push_item
);
    import u8d_pkg::*;

    assign text.ready = !q_full;
    assign push       = text.valid && !q_full;

    // classify the byte on its own; the back end decides what it means in context
    always_comb
    begin
        push_item.last = text.message_end;
        push_item.bits = '0;
        if (text.text_byte inside {[8'h00:8'h7F]})
        begin
            push_item.cls  = CLS_ASCII;
            push_item.bits = text.text_byte[6:0];
        end
        else if (text.text_byte inside {[8'h80:8'hBF]})
        begin
            push_item.cls  = CLS_CONT;
            push_item.bits = {1'b0, text.text_byte[5:0]};
        end
        else if (text.text_byte inside {[8'hC2:8'hDF]})
        begin
            push_item.cls  = CLS_LEAD2;
            push_item.bits = {2'b0, text.text_byte[4:0]};
        end
        else if (text.text_byte inside {[8'hE0:8'hEF]})
        begin
            push_item.cls  = CLS_LEAD3;
            push_item.bits = {3'b0, text.text_byte[3:0]};
        end
        else if (text.text_byte inside {[8'hF0:8'hF4]})
        begin
            push_item.cls  = CLS_LEAD4;
            push_item.bits = {4'b0, text.text_byte[2:0]};
        end
        else
        begin
            push_item.cls = CLS_BAD;
        end
    end

endmodule

// ===== hdl/u8d_fifo.sv =====
module u8d_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8d_pkg::u8d_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output u8d_pkg::u8d_item_t  q_item
);
    import u8d_pkg::*;

    u8d_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == QPTR_W'(rd_ptr_reg + count_reg[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

// ===== hdl/u8d_back.sv =====
module u8d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  u8d_pkg::u8d_item_t  q_item,
    output logic                pop,
    u8d_out_if.source           decoded
);
    import u8d_pkg::*;

    logic [CP_W-1:0]   partial_reg, partial_next;
    logic [CNT_W-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]  seqlen_reg,  seqlen_next;
    logic              skip_reg,    skip_next;
    logic              out_valid_reg, out_valid_next;
    logic [CP_W-1:0]   code_point_reg;
    logic              invalid_reg;
    logic              run_last_reg;

    logic              err;
    logic              res_valid;
    logic [CP_W-1:0]   res_cp;
    logic              res_last;
    logic [CP_W-1:0]   cp_full;
    logic [CP_W-1:0]   cp_min;

    assign pop = q_valid && (!out_valid_reg || decoded.ready);

    assign cp_full = {partial_reg[CP_W-7:0], q_item.bits[5:0]};

    always_comb
    begin
        case (seqlen_reg)
            2'd1:    cp_min = MIN_TWO_BYTE;
            2'd2:    cp_min = MIN_THREE_BYTE;
            default: cp_min = MIN_FOUR_BYTE;
        endcase
    end

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        seqlen_next  = seqlen_reg;
        skip_next    = skip_reg;
        err          = 1'b0;
        res_valid    = 1'b0;
        res_cp       = '0;
        res_last     = q_item.last;

        if (skip_reg)
        begin
            // drop the rest of a malformed message
            if (q_item.last)
                skip_next = 1'b0;
        end
        else if (pending_reg == '0)
        begin
            case (q_item.cls)
                CLS_ASCII:
                begin
                    res_valid = 1'b1;
                    res_cp    = CP_W'(q_item.bits);
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
                begin
                    partial_next = CP_W'(q_item.bits);
                    case (q_item.cls)
                        CLS_LEAD2: seqlen_next = 2'd1;
                        CLS_LEAD3: seqlen_next = 2'd2;
                        default:   seqlen_next = 2'd3;
                    endcase
                    pending_next = seqlen_next;
                    err          = q_item.last;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end
        else if (q_item.cls != CLS_CONT)
        begin
            err = 1'b1;
        end
        else if (pending_reg == 2'd1)
        begin
            // sequence complete: check range, surrogates and overlong forms
            partial_next = '0;
            pending_next = '0;
            seqlen_next  = '0;
            if (cp_full < cp_min || cp_full > MAX_SCALAR
                || (cp_full >= SURROGATE_LO && cp_full <= SURROGATE_HI))
            begin
                err = 1'b1;
            end
            else
            begin
                res_valid = 1'b1;
                res_cp    = cp_full;
            end
        end
        else
        begin
            partial_next = cp_full;
            pending_next = pending_reg - 1'b1;
            err          = q_item.last;
        end

        if (err)
        begin
            partial_next = '0;
            pending_next = '0;
            seqlen_next  = '0;
            skip_next    = !q_item.last;
            res_valid    = 1'b1;
            res_cp       = '0;
            res_last     = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && res_valid)
            out_valid_next = 1'b1;
        else if (decoded.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            pending_reg   <= '0;
            seqlen_reg    <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                partial_reg <= partial_next;
                pending_reg <= pending_next;
                seqlen_reg  <= seqlen_next;
                skip_reg    <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            code_point_reg <= res_cp;
            invalid_reg    <= err;
            run_last_reg   <= res_last;
        end
    end

    assign decoded.valid      = out_valid_reg;
    assign decoded.code_point = code_point_reg;
    assign decoded.invalid    = invalid_reg;
    assign decoded.run_last   = run_last_reg;

    a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && invalid_reg |-> run_last_reg && code_point_reg == '0)
        else $error("invalid result must be last with zero code point");

    a_skip_idle: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> pending_reg == '0 && seqlen_reg == '0)
        else $error("skipping while a sequence is open");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != '0 |-> seqlen_reg != '0 && pending_reg <= seqlen_reg)
        else $error("pending count exceeds sequence length");

endmodule
